// File: design/spo_pkg.sv
// Shared constants and types for the suffix/prefix overlap block.
package spo_pkg;

	localparam int MAX_LEN = 128;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int SYM_W   = 8;
	localparam int OVL_W   = 8;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic load;   // shift a first-string symbol into the row
		logic shift;  // second-string symbol: compare and pass match bits down
		logic clear;  // pair finished: reset match bits
	} cell_ctrl_t;

endpackage

// File: design/spo_cell.sv
// One cell of the row: a stored first-string symbol and one match bit.
module spo_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spo_pkg::cell_ctrl_t      ctrl,
	input  logic [spo_pkg::SYM_W-1:0] symbol,
	input  logic [spo_pkg::SYM_W-1:0] data_in,
	input  logic                     hit_in,
	output logic [spo_pkg::SYM_W-1:0] data,
	output logic                     hit
);
	import spo_pkg::*;

	logic [SYM_W-1:0] data_q;
	logic             match_q;

	// candidate survives this symbol if still matching and the byte agrees
	assign hit  = match_q & (data_q == symbol);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
		end else if (ctrl.clear) begin
			match_q <= 1'b1;
		end else if (ctrl.shift) begin
			match_q <= hit_in;
		end
	end

endmodule

// File: design/spo_ctrl.sv
// Length counters, best-overlap tracking and output register.
module spo_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      string_select,
	input  logic                      end_of_pair,
	input  logic                      cell_hit,
	output spo_pkg::cell_ctrl_t       ctrl,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [spo_pkg::OVL_W-1:0] overlap_length,
	output logic                      length_overflow
);
	import spo_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] best_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [OVL_W-1:0] out_len_q;
	logic             out_ovf_q;

	logic             take;
	logic             x_take;
	logic             x_drop;
	logic             y_take;
	logic             y_drop;
	logic             hit_now;
	logic             done;
	logic [LEN_W-1:0] best_nx;
	logic             ovf_nx;

	assign in_stall = out_valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	// first-string words are ignored once the second string has begun
	assign x_take  = take & ~string_select & (pos_q == '0) & (len_q < LEN_W'(MAX_LEN));
	assign x_drop  = take & ~string_select & (pos_q == '0) & (len_q >= LEN_W'(MAX_LEN));
	assign y_take  = take & string_select & (pos_q < LEN_W'(MAX_LEN));
	assign y_drop  = take & string_select & (pos_q >= LEN_W'(MAX_LEN));
	assign done    = take & end_of_pair;

	// cell 0 holds the candidate that completes on this word: length pos+1
	assign hit_now = y_take & (pos_q < len_q) & cell_hit;
	assign best_nx = hit_now ? (pos_q + LEN_W'(1)) : best_q;
	assign ovf_nx  = ovf_q | x_drop | y_drop;

	always_comb begin
		ctrl.load  = x_take;
		ctrl.shift = y_take;
		ctrl.clear = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pos_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (done) begin
			len_q  <= '0;
			pos_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (x_take) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (y_take) begin
				pos_q <= pos_q + LEN_W'(1);
			end
			best_q <= best_nx;
			ovf_q  <= ovf_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_len_q <= OVL_W'(best_nx);
			out_ovf_q <= ovf_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign overlap_length  = out_len_q;
	assign length_overflow = out_ovf_q;

endmodule

// File: design/suffix_prefix_overlap_top.sv
// Longest suffix/prefix overlap of two byte strings: cell row plus control.
//
// Feed the first string, then the second, one word per clock; end_of_pair marks
// the last word of the pair and yields one result word. A row of MAX_LEN cells
// keeps the first string stationary and moves one match bit per remaining
// candidate length down the row on each second-string word, so all candidates
// are checked in parallel and cell 0 delivers the candidate that completes on
// that word. The result is registered and shows on out_valid the cycle after
// the end_of_pair word. Input stalls only while a result is held with out_stall
// high. Strings longer than MAX_LEN are truncated and reported through
// length_overflow.
module suffix_prefix_overlap_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      string_select,
	input  logic [spo_pkg::SYM_W-1:0] symbol,
	input  logic                      end_of_pair,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [spo_pkg::OVL_W-1:0] overlap_length,
	output logic                      length_overflow
);
	import spo_pkg::*;

	cell_ctrl_t       ctrl;
	logic [SYM_W-1:0] data_w [MAX_LEN];
	logic             hit_w  [MAX_LEN+1];

	// candidates beyond the row never reach cell 0 in a meaningful pair
	assign hit_w[MAX_LEN] = 1'b1;

	spo_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.string_select   (string_select),
		.end_of_pair     (end_of_pair),
		.cell_hit        (hit_w[0]),
		.ctrl            (ctrl),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.overlap_length  (overlap_length),
		.length_overflow (length_overflow)
	);

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic [SYM_W-1:0] data_in;

		// first-string words enter at cell 0 and push older ones up
		if (i == 0) begin : g_head
			assign data_in = symbol;
		end else begin : g_body
			assign data_in = data_w[i-1];
		end

		spo_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.symbol  (symbol),
			.data_in (data_in),
			.hit_in  (hit_w[i+1]),
			.data    (data_w[i]),
			.hit     (hit_w[i])
		);
	end

endmodule
